/* sv/sdes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdes_pkg: shared types and constants of the slew sensing de-esser
// Widths, fixed-point constants, sequencer codes and the request record of
// the shared multiply-divide unit.
// ----------------------------------------------------------------------------
package sdes_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 24;

  localparam int MA_W   = 52;            // multiplicand
  localparam int MB_W   = 40;            // multiplier
  localparam int MD_W   = 41;            // divisor
  localparam int RES_W  = 64;
  localparam int PROD_W = MA_W + MB_W;
  localparam int CNT_W  = 7;

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] RECOV = (ONE_Q + 64'd50) / 64'd100;
  localparam logic [63:0] ATT_BASE = ONE_Q << 3;
  // sense = p2 * 1000 / 2197 as p2 * ceil(1000 * 2^42 / 2197) >> 42
  localparam logic [MA_W-1:0] SENSE_RECIP = 52'd2001841834823;
  localparam int              SENSE_SHIFT = 42;

  typedef struct packed {
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
    logic [MD_W-1:0] d;
    logic            div;
  } mdu_req_t;

  typedef enum logic [1:0] {MS_IDLE, MS_MUL, MS_DIV} mdu_st_e;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} seq_st_e;

  typedef enum logic [3:0] {
    OP_PM, OP_P2, OP_SENSE, OP_IG2, OP_T, OP_K, OP_STEP, OP_RATIO, OP_M
  } op_e;

  typedef enum logic [1:0] {
    REG_INTENSITY  = 2'd0,
    REG_MAX_RATIO  = 2'd1,
    REG_IIR_AMOUNT = 2'd2
  } cfg_reg_e;

endpackage
`default_nettype wire

/* sv/sdes_mdu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdes_mdu: shared multiply-divide unit
// Forms a*b one bit a cycle, then either takes bits FRAC_BITS up or divides
// the low 64 bits by d one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sdes_mdu (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire sdes_pkg::mdu_req_t        req_i,
  output logic                           done_o,
  output logic [sdes_pkg::RES_W-1:0]     res_o
);
  import sdes_pkg::*;

  mdu_st_e            st_q, st_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [MA_W-1:0]    a_q, a_d;
  logic [MD_W-1:0]    d_q, d_d;
  logic               div_q, div_d;
  logic [MA_W-1:0]    hi_q, hi_d;
  logic [MB_W-1:0]    lo_q, lo_d;
  logic [MD_W-1:0]    rem_q, rem_d;
  logic [RES_W-1:0]   dv_q, dv_d;

  logic [MA_W:0]      sum;
  logic [PROD_W-1:0]  prod;
  logic [MD_W:0]      rem_sh;
  logic [MD_W:0]      rem_sub;
  logic               ge;

  always_comb begin
    sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    prod    = {hi_q, lo_q};
    rem_sh  = {rem_q, dv_q[RES_W-1]};
    ge      = rem_sh >= {1'b0, d_q};
    rem_sub = rem_sh - {1'b0, d_q};

    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    a_d    = a_q;
    d_d    = d_q;
    div_d  = div_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    rem_d  = rem_q;
    dv_d   = dv_q;

    unique case (st_q)
      MS_IDLE: begin
        if (start_i) begin
          a_d   = req_i.a;
          d_d   = req_i.d;
          div_d = req_i.div;
          hi_d  = '0;
          lo_d  = req_i.b;
          cnt_d = CNT_W'(MB_W);
          st_d  = MS_MUL;
        end
      end
      MS_MUL: begin
        if (cnt_q == '0) begin
          if (div_q) begin
            dv_d  = prod[RES_W-1:0];
            rem_d = '0;
            cnt_d = CNT_W'(RES_W);
            st_d  = MS_DIV;
          end else begin
            dv_d   = prod[FRAC_BITS+RES_W-1:FRAC_BITS];
            done_d = 1'b1;
            st_d   = MS_IDLE;
          end
        end else begin
          hi_d  = sum[MA_W:1];
          lo_d  = {sum[0], lo_q[MB_W-1:1]};
          cnt_d = cnt_q - 1'b1;
        end
      end
      MS_DIV: begin
        if (cnt_q == '0) begin
          done_d = 1'b1;
          st_d   = MS_IDLE;
        end else begin
          rem_d = ge ? rem_sub[MD_W-1:0] : rem_sh[MD_W-1:0];
          dv_d  = {dv_q[RES_W-2:0], ge};
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: st_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MS_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    d_q   <= d_d;
    div_q <= div_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o = done_q;
  assign res_o  = dv_q;

endmodule
`default_nettype wire

/* sv/slew_sensing_deesser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slew_sensing_deesser: slew sensing de-esser, one stereo frame per item
// A sequencer runs nine operations per channel through one shared
// multiply-divide unit.
// ----------------------------------------------------------------------------
// Sequence: each operation passes through the bit-serial multiplier, and
// each of the two divides per channel then runs through the divider; the
// result is finally loaded into the output register.
// Flow: one item is in work at a time; the next item is taken as soon as
// the result sits in the output register, even if it is not yet taken.
// Reset: history and lowpass levels clear, ratios go to one, phase to zero.
// ----------------------------------------------------------------------------
module slew_sensing_deesser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_idx_i,
  input  wire logic [29:0]                     cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // left_sample, right_sample
  input  wire logic [2*sdes_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // left_out, right_out
  output logic [2*sdes_pkg::SAMPLE_BITS-1:0]   m_axis_tdata
);
  import sdes_pkg::*;

  localparam int SB = SAMPLE_BITS;

  seq_st_e            st_q, st_d;
  op_e                op_q, op_d;
  logic               ch_q, ch_d;
  logic               phase_q, phase_d;
  logic               out_valid_q, out_valid_d;
  logic [2*SB-1:0]    out_data_q, out_data_d;
  logic [29:0]        ig_cfg_q, ig_cfg_d;
  logic [23:0]        mr_q, mr_d;
  logic [16:0]        iir_q, iir_d;

  logic signed [SB-1:0] x_q [2];
  logic signed [SB-1:0] x_d [2];
  logic signed [SB-1:0] hnew_q [2];
  logic signed [SB-1:0] hnew_d [2];
  logic signed [SB-1:0] hold_q [2];
  logic signed [SB-1:0] hold_d [2];
  logic signed [SB:0]   lp_q [4];
  logic signed [SB:0]   lp_d [4];
  logic [31:0]          r_q [4];
  logic [31:0]          r_d [4];

  logic [26:0]        pm_q, pm_d;
  logic [29:0]        p2_q, p2_d;
  logic [29:0]        sense_q, sense_d;
  logic [51:0]        ig2_q, ig2_d;
  logic [37:0]        tgt_q, tgt_d;
  logic [24:0]        k_q, k_d;
  logic [SB-1:0]      yl_q, yl_d;
  logic [SB-1:0]      yr_q, yr_d;

  logic               mdu_start;
  mdu_req_t           req;
  logic               mdu_done;
  logic [RES_W-1:0]   res;

  logic [1:0]         idx;
  logic signed [SB:0] xq, s2q, s3q;
  logic signed [SB+1:0] d1, ds, diff;
  logic signed [SB+2:0] dd;
  logic [SB+1:0]      d1_mag, diff_mag;
  logic [SB+2:0]      dd_mag;
  logic [SB:0]        xq_mag;
  logic [SB:0]        one_m_x;
  logic signed [SB:0] lp_cur;
  logic [31:0]        r_cur;
  logic               r_up, r_dn;
  logic [40:0]        att1;
  logic [37:0]        ig;
  logic [24:0]        amt;
  logic [31:0]        cap;
  logic [58:0]        tgt_full;
  logic signed [SB+1:0] lp_sum;
  logic [38:0]        r_t;
  logic [38:0]        r_c;
  logic signed [SB+2:0] y;
  logic signed [SB+1:0] ysh;
  logic [SB-1:0]      y_sat;

  sdes_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdu_start),
    .req_i   (req),
    .done_o  (mdu_done),
    .res_o   (res)
  );

  always_comb begin
    idx      = {ch_q, phase_q};
    xq       = {x_q[ch_q], 1'b0};
    s2q      = {hnew_q[ch_q], 1'b0};
    s3q      = {hold_q[ch_q], 1'b0};
    d1       = {xq[SB], xq} - {s2q[SB], s2q};
    ds       = {s2q[SB], s2q} - {s3q[SB], s3q};
    dd       = {d1[SB+1], d1} - {ds[SB+1], ds};
    d1_mag   = d1[SB+1] ? (SB+2)'(-d1) : (SB+2)'(d1);
    dd_mag   = dd[SB+2] ? (SB+3)'(-dd) : (SB+3)'(dd);
    xq_mag   = xq[SB] ? (SB+1)'(-xq) : (SB+1)'(xq);
    one_m_x  = (SB+1)'(ONE_Q) - xq_mag;
    lp_cur   = lp_q[idx];
    diff     = {xq[SB], xq} - {lp_cur[SB], lp_cur};
    diff_mag = diff[SB+1] ? (SB+2)'(-diff) : (SB+2)'(diff);
    r_cur    = r_q[idx];
    r_up     = {6'b0, r_cur} < tgt_q;
    r_dn     = r_cur > 32'(ONE_Q);
    att1     = 41'(ATT_BASE) + ({11'b0, sense_q} << 10);
    ig       = {ig_cfg_q, 8'b0};
    amt      = {(iir_q > 17'd65536 ? 17'd65536 : iir_q), 8'b0};
    cap      = {(mr_q < 24'd65536 ? 24'd65536 : mr_q), 8'b0};

    tgt_full = 59'(ONE_Q) + {1'b0, res[57:0]};
    lp_sum   = diff[SB+1] ? ({lp_cur[SB], lp_cur} - {1'b0, res[SB:0]})
                          : ({lp_cur[SB], lp_cur} + {1'b0, res[SB:0]});
    if (r_up) begin
      r_t = {7'b0, r_cur} + res[38:0];
    end else if (r_dn) begin
      r_t = {7'b0, r_cur} - res[38:0];
    end else begin
      r_t = {7'b0, r_cur};
    end
    r_c = (r_t > {7'b0, cap}) ? {7'b0, cap} : r_t;
    if (r_c < 39'(ONE_Q)) begin
      r_c = 39'(ONE_Q);
    end
    y    = diff[SB+1] ? ({{2{lp_cur[SB]}}, lp_cur} - {1'b0, res[SB+1:0]})
                      : ({{2{lp_cur[SB]}}, lp_cur} + {1'b0, res[SB+1:0]});
    ysh  = y[SB+2:1];
    if (ysh[SB+1:SB-1] == 3'b000 || ysh[SB+1:SB-1] == 3'b111) begin
      y_sat = ysh[SB-1:0];
    end else if (ysh[SB+1]) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end

    req = '0;
    req.d = MD_W'(1);
    unique case (op_q)
      OP_PM: begin
        req.a = MA_W'(d1_mag);
        req.b = MB_W'(dd_mag);
      end
      OP_P2: begin
        req.a = MA_W'(pm_q);
        req.b = MB_W'(pm_q);
      end
      OP_SENSE: begin
        req.a = SENSE_RECIP;
        req.b = MB_W'(p2_q);
      end
      OP_IG2: begin
        req.a = MA_W'(ig);
        req.b = MB_W'(ig);
      end
      OP_T: begin
        req.a = ig2_q;
        req.b = MB_W'(sense_q);
      end
      OP_K: begin
        req.a = MA_W'(one_m_x);
        req.b = MB_W'(amt);
      end
      OP_STEP: begin
        req.a = MA_W'(diff_mag);
        req.b = MB_W'(k_q);
      end
      OP_RATIO: begin
        req.div = 1'b1;
        if (r_up) begin
          req.a = MA_W'(tgt_q - {6'b0, r_cur});
          req.b = MB_W'(ONE_Q);
          req.d = att1;
        end else if (r_dn) begin
          req.a = MA_W'(r_cur - 32'(ONE_Q));
          req.b = MB_W'(RECOV);
          req.d = MD_W'(tgt_q) + MD_W'(RECOV);
        end
      end
      OP_M: begin
        req.a   = MA_W'(diff_mag);
        req.b   = MB_W'(ONE_Q);
        req.d   = MD_W'(r_cur);
        req.div = 1'b1;
      end
      default: req = '0;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    op_d        = op_q;
    ch_d        = ch_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ig_cfg_d    = ig_cfg_q;
    mr_d        = mr_q;
    iir_d       = iir_q;
    x_d         = x_q;
    hnew_d      = hnew_q;
    hold_d      = hold_q;
    lp_d        = lp_q;
    r_d         = r_q;
    pm_d        = pm_q;
    p2_d        = p2_q;
    sense_d     = sense_q;
    ig2_d       = ig2_q;
    tgt_d       = tgt_q;
    k_d         = k_q;
    yl_d        = yl_q;
    yr_d        = yr_q;
    mdu_start   = 1'b0;
    s_axis_tready = (st_q == ST_IDLE);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INTENSITY:  ig_cfg_d = cfg_data_i;
        REG_MAX_RATIO:  mr_d     = cfg_data_i[23:0];
        REG_IIR_AMOUNT: iir_d    = cfg_data_i[16:0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          x_d[0] = s_axis_tdata[SB-1:0];
          x_d[1] = s_axis_tdata[2*SB-1:SB];
          ch_d   = 1'b0;
          op_d   = OP_PM;
          st_d   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mdu_start = 1'b1;
        if (op_q == OP_PM) begin
          hold_d[ch_q] = hnew_q[ch_q];
          hnew_d[ch_q] = x_q[ch_q];
        end
        st_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mdu_done) begin
          op_d = op_e'(op_q + 4'd1);
          st_d = ST_ISSUE;
          unique case (op_q)
            OP_PM:    pm_d    = res[26:0];
            OP_P2:    p2_d    = res[29:0];
            OP_SENSE: sense_d = res[SENSE_SHIFT-FRAC_BITS +: 30];
            OP_IG2:   ig2_d   = res[51:0];
            OP_T:     tgt_d   = (tgt_full > {21'b0, ig}) ? ig : tgt_full[37:0];
            OP_K:     k_d     = res[24:0];
            OP_STEP:  lp_d[idx] = lp_sum[SB:0];
            OP_RATIO: r_d[idx]  = r_c[31:0];
            OP_M: begin
              op_d = OP_PM;
              if (!ch_q) begin
                yl_d = y_sat;
                ch_d = 1'b1;
              end else begin
                yr_d = y_sat;
                st_d = ST_OUT;
              end
            end
            default: op_d = OP_PM;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {yr_q, yl_q};
          out_valid_d = 1'b1;
          phase_d     = ~phase_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      op_q        <= OP_PM;
      ch_q        <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ig_cfg_q    <= 30'd65536;
      mr_q        <= 24'd65536;
      iir_q       <= '0;
      for (int i = 0; i < 2; i++) begin
        hnew_q[i] <= '0;
        hold_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        lp_q[i] <= '0;
        r_q[i]  <= 32'(ONE_Q);
      end
    end else begin
      st_q        <= st_d;
      op_q        <= op_d;
      ch_q        <= ch_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      ig_cfg_q    <= ig_cfg_d;
      mr_q        <= mr_d;
      iir_q       <= iir_d;
      hnew_q      <= hnew_d;
      hold_q      <= hold_d;
      lp_q        <= lp_d;
      r_q         <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    x_q        <= x_d;
    pm_q       <= pm_d;
    p2_q       <= p2_d;
    sense_q    <= sense_d;
    ig2_q      <= ig2_d;
    tgt_q      <= tgt_d;
    k_q        <= k_d;
    yl_q       <= yl_d;
    yr_q       <= yr_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
